@@ rtl/prgb_pkg.sv @@
`timescale 1ns / 1ps

package prgb_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SHOW  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEDS_IN_USE = 3'd0,
    CFG_HIGH_TICKS  = 3'd1,
    CFG_DATA_TICKS  = 3'd2,
    CFG_LOW_TICKS   = 3'd3,
    CFG_RESET_TICKS = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LINES_W    = 8;
  localparam int STRIP_W    = 3;
  localparam int LED_W      = 5;
  localparam int COLOR_W    = 24;
  localparam int TICK_W     = 16;
  localparam int BIT_W      = 5;

  // Register reset values
  localparam logic [5:0]  LEDS_RST  = 6'd30;
  localparam logic [7:0]  HIGH_RST  = 8'd7;
  localparam logic [7:0]  DATA_RST  = 8'd6;
  localparam logic [7:0]  LOW_RST   = 8'd7;
  localparam logic [15:0] RESET_RST = 16'd1000;

  // Controller states: the four waveform phases plus the store clearing sweep
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_DATA
  } state_t;

  // Phase tick counter operations
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_DEC,
    CNT_RESET,
    CNT_HIGH,
    CNT_DATA,
    CNT_LOW
  } cnt_op_t;

  // Line level register operations
  typedef enum logic [1:0] {
    LV_KEEP,
    LV_ZERO,
    LV_ALL,
    LV_DATA
  } lv_op_t;

  typedef struct packed {
    logic    sweep_en;
    logic    wr_en;
    cnt_op_t cnt_op;
    logic    idx_clr;
    logic    bit_adv;
    lv_op_t  lv_op;
    logic    out_load;
    logic    out_busy;
    logic    out_done;
  } cmd_t;

  typedef struct packed {
    logic cnt_gt1;
    logic led_done;
    logic sweep_last;
  } stat_t;

endpackage

@@ rtl/prgb_if.sv @@
`timescale 1ns / 1ps

// Request channel
interface prgb_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [prgb_pkg::STRIP_W-1:0]  strip;
  logic [prgb_pkg::LED_W-1:0]    led;
  logic [prgb_pkg::COLOR_W-1:0]  color;

  modport source (output valid, req_type, strip, led, color, input ready);
  modport sink   (input valid, req_type, strip, led, color, output ready);
endinterface

// Result channel
interface prgb_res_if;
  logic                          valid;
  logic                          ready;
  logic [prgb_pkg::LINES_W-1:0]  lines;
  logic                          busy_res;
  logic                          frame_done;

  modport source (output valid, lines, busy_res, frame_done, input ready);
  modport sink   (input valid, lines, busy_res, frame_done, output ready);
endinterface

@@ rtl/prgb_dpath.sv @@
`timescale 1ns / 1ps

module prgb_dpath #(
  parameter int STRIP_COUNT = 8,
  parameter int MAX_LEDS    = 32,
  parameter int COLOR_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [prgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prgb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [prgb_pkg::STRIP_W-1:0]      strip,
  input  logic [prgb_pkg::LED_W-1:0]        led,
  input  logic [prgb_pkg::COLOR_W-1:0]      color,
  input  prgb_pkg::cmd_t                    cmd,
  output prgb_pkg::stat_t                   st,
  output logic [prgb_pkg::LINES_W-1:0]      lines,
  output logic                              busy_res,
  output logic                              frame_done
);

  localparam int LW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int IW   = $clog2(MAX_LEDS + 1);
  localparam int CMPW = (IW > 6) ? IW : 6;
  localparam int AXW  = (LW > prgb_pkg::LED_W) ? LW : prgb_pkg::LED_W;
  localparam int BXW  = prgb_pkg::BIT_W + 1;
  localparam logic [prgb_pkg::LINES_W-1:0] ALL_LINES =
    prgb_pkg::LINES_W'((64'd1 << STRIP_COUNT) - 64'd1);

  // Configuration registers
  logic [5:0]  leds_r,  leds_nxt;
  logic [7:0]  high_r,  high_nxt;
  logic [7:0]  data_r,  data_nxt;
  logic [7:0]  low_r,   low_nxt;
  logic [15:0] rst_t_r, rst_t_nxt;

  always_comb begin
    leds_nxt  = leds_r;
    high_nxt  = high_r;
    data_nxt  = data_r;
    low_nxt   = low_r;
    rst_t_nxt = rst_t_r;
    if (cfg_we) begin
      case (cfg_index)
        prgb_pkg::CFG_LEDS_IN_USE: leds_nxt  = cfg_wdata[5:0];
        prgb_pkg::CFG_HIGH_TICKS:  high_nxt  = cfg_wdata[7:0];
        prgb_pkg::CFG_DATA_TICKS:  data_nxt  = cfg_wdata[7:0];
        prgb_pkg::CFG_LOW_TICKS:   low_nxt   = cfg_wdata[7:0];
        prgb_pkg::CFG_RESET_TICKS: rst_t_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leds_r  <= prgb_pkg::LEDS_RST;
      high_r  <= prgb_pkg::HIGH_RST;
      data_r  <= prgb_pkg::DATA_RST;
      low_r   <= prgb_pkg::LOW_RST;
      rst_t_r <= prgb_pkg::RESET_RST;
    end else begin
      leds_r  <= leds_nxt;
      high_r  <= high_nxt;
      data_r  <= data_nxt;
      low_r   <= low_nxt;
      rst_t_r <= rst_t_nxt;
    end
  end

  // Clearing sweep address, one LED row per cycle
  logic [LW-1:0] sweep_r, sweep_nxt;

  assign st.sweep_last = (sweep_r == LW'(MAX_LEDS - 1));

  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd.sweep_en) begin
      sweep_nxt = st.sweep_last ? '0 : sweep_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else begin
      sweep_r <= sweep_nxt;
    end
  end

  // Phase tick counter; a programmed zero counts as one
  logic [prgb_pkg::TICK_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    case (cmd.cnt_op)
      prgb_pkg::CNT_DEC:   cnt_nxt = cnt_r - 16'd1;
      prgb_pkg::CNT_RESET: cnt_nxt = (rst_t_r == 16'd0) ? 16'd1 : rst_t_r;
      prgb_pkg::CNT_HIGH:  cnt_nxt = (high_r == 8'd0) ? 16'd1 : {8'd0, high_r};
      prgb_pkg::CNT_DATA:  cnt_nxt = (data_r == 8'd0) ? 16'd1 : {8'd0, data_r};
      prgb_pkg::CNT_LOW:   cnt_nxt = (low_r == 8'd0) ? 16'd1 : {8'd0, low_r};
      default:             cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign st.cnt_gt1 = (cnt_r > 16'd1);

  // Bit and LED position
  logic [prgb_pkg::BIT_W-1:0] bit_r, bit_nxt;
  logic [IW-1:0]              led_idx_r, led_idx_nxt;
  logic [BXW-1:0]             bit_inc;

  always_comb begin
    bit_inc     = {1'b0, bit_r} + BXW'(1);
    bit_nxt     = bit_r;
    led_idx_nxt = led_idx_r;
    if (cmd.idx_clr) begin
      bit_nxt     = '0;
      led_idx_nxt = '0;
    end else if (cmd.bit_adv) begin
      if (bit_inc >= BXW'(COLOR_BITS)) begin
        bit_nxt     = '0;
        led_idx_nxt = led_idx_r + IW'(1);
      end else begin
        bit_nxt = bit_inc[prgb_pkg::BIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r     <= '0;
      led_idx_r <= '0;
    end else begin
      bit_r     <= bit_nxt;
      led_idx_r <= led_idx_nxt;
    end
  end

  // LEDs sent per frame, clamped to one .. MAX_LEDS
  logic [5:0]      leds_min1;
  logic [CMPW-1:0] frame_leds;

  always_comb begin
    leds_min1  = (leds_r == 6'd0) ? 6'd1 : leds_r;
    frame_leds = (CMPW'(leds_min1) > CMPW'(MAX_LEDS)) ? CMPW'(MAX_LEDS) : CMPW'(leds_min1);
  end

  assign st.led_done = (CMPW'(led_idx_r) >= frame_leds);

  // Colour store: one memory per strip, row address is the LED position
  logic [AXW-1:0]             led_x;
  logic [LW-1:0]              wr_addr;
  logic [prgb_pkg::COLOR_W-1:0] wr_data;
  logic                       set_ok;
  logic [LW-1:0]              rd_addr;
  logic [prgb_pkg::COLOR_W-1:0] rd_q [STRIP_COUNT];

  always_comb begin
    led_x   = AXW'(led);
    set_ok  = (32'(strip) < STRIP_COUNT) && (32'(led) < MAX_LEDS);
    wr_addr = cmd.sweep_en ? sweep_r : led_x[LW-1:0];
    wr_data = cmd.sweep_en ? '0 : color;
    rd_addr = led_idx_r[LW-1:0];
  end

  for (genvar s = 0; s < STRIP_COUNT; s++) begin : g_lane
    logic [prgb_pkg::COLOR_W-1:0] mem [MAX_LEDS];
    logic                         lane_we;

    assign lane_we = cmd.sweep_en ||
                     (cmd.wr_en && set_ok && (strip == prgb_pkg::STRIP_W'(s)));

    always_ff @(posedge clk) begin
      if (lane_we) begin
        mem[wr_addr] <= wr_data;
      end
      rd_q[s] <= mem[rd_addr];
    end
  end

  // Data bit of each strip for the current LED and bit position
  logic [prgb_pkg::BIT_W-1:0]   pos;
  logic [prgb_pkg::LINES_W-1:0] data_bits;

  always_comb begin
    pos       = prgb_pkg::BIT_W'(COLOR_BITS - 1) - bit_r;
    data_bits = '0;
    if (pos <= prgb_pkg::BIT_W'(prgb_pkg::COLOR_W - 1)) begin
      for (int s = 0; s < STRIP_COUNT; s++) begin
        data_bits[s] = rd_q[s][pos];
      end
    end
  end

  // Line levels
  logic [prgb_pkg::LINES_W-1:0] lv_r, lv_nxt;

  always_comb begin
    case (cmd.lv_op)
      prgb_pkg::LV_ZERO: lv_nxt = '0;
      prgb_pkg::LV_ALL:  lv_nxt = ALL_LINES;
      prgb_pkg::LV_DATA: lv_nxt = data_bits;
      default:           lv_nxt = lv_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else begin
      lv_r <= lv_nxt;
    end
  end

  // Result register: levels seen during the request's clock
  logic [prgb_pkg::LINES_W-1:0] lines_r;
  logic                         busy_r;
  logic                         done_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lines_r <= lv_r;
      busy_r  <= cmd.out_busy;
      done_r  <= cmd.out_done;
    end
  end

  assign lines      = lines_r;
  assign busy_res   = busy_r;
  assign frame_done = done_r;

  // Line levels are only ever set on lanes that exist
  a_lv_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (lv_r & ~ALL_LINES) == '0)
    else $error("line level set on a lane that does not exist");

endmodule

@@ rtl/prgb_ctrl.sv @@
`timescale 1ns / 1ps

module prgb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      req_type,
  output logic            out_valid,
  input  logic            out_ready,
  input  prgb_pkg::stat_t st,
  output prgb_pkg::cmd_t  cmd
);

  prgb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  prgb_pkg::req_t   req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prgb_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    req          = prgb_pkg::req_t'(req_type);
    in_ready     = (state_r != prgb_pkg::ST_CLEAR) && (!out_valid_r || out_ready);
    accept       = in_valid && in_ready;
    state_nxt    = state_r;
    cmd          = '0;
    cmd.cnt_op   = prgb_pkg::CNT_HOLD;
    cmd.lv_op    = prgb_pkg::LV_KEEP;
    cmd.out_load = accept;

    if (state_r == prgb_pkg::ST_CLEAR) begin
      cmd.sweep_en = 1'b1;
      if (st.sweep_last) begin
        state_nxt = prgb_pkg::ST_IDLE;
      end
    end else if (accept) begin
      if (req == prgb_pkg::REQ_TICK) begin
        if (state_r != prgb_pkg::ST_IDLE) begin
          if (st.cnt_gt1) begin
            cmd.cnt_op = prgb_pkg::CNT_DEC;
          end else begin
            case (state_r)
              prgb_pkg::ST_LOW: begin
                if (st.led_done) begin
                  state_nxt    = prgb_pkg::ST_IDLE;
                  cmd.lv_op    = prgb_pkg::LV_ZERO;
                  cmd.out_done = 1'b1;
                end else begin
                  state_nxt  = prgb_pkg::ST_HIGH;
                  cmd.cnt_op = prgb_pkg::CNT_HIGH;
                  cmd.lv_op  = prgb_pkg::LV_ALL;
                end
              end
              prgb_pkg::ST_HIGH: begin
                state_nxt  = prgb_pkg::ST_DATA;
                cmd.cnt_op = prgb_pkg::CNT_DATA;
                cmd.lv_op  = prgb_pkg::LV_DATA;
              end
              prgb_pkg::ST_DATA: begin
                state_nxt   = prgb_pkg::ST_LOW;
                cmd.cnt_op  = prgb_pkg::CNT_LOW;
                cmd.lv_op   = prgb_pkg::LV_ZERO;
                cmd.bit_adv = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end else if (state_r == prgb_pkg::ST_IDLE) begin
        case (req)
          prgb_pkg::REQ_SET:   cmd.wr_en = 1'b1;
          prgb_pkg::REQ_CLEAR: state_nxt = prgb_pkg::ST_CLEAR;
          prgb_pkg::REQ_SHOW: begin
            state_nxt   = prgb_pkg::ST_LOW;
            cmd.cnt_op  = prgb_pkg::CNT_RESET;
            cmd.lv_op   = prgb_pkg::LV_ZERO;
            cmd.idx_clr = 1'b1;
          end
          default: ;
        endcase
      end
    end

    cmd.out_busy = (state_nxt != prgb_pkg::ST_IDLE) && (state_nxt != prgb_pkg::ST_CLEAR);
  end

  // Result register occupancy
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // Nothing is taken while the store is being swept
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prgb_pkg::ST_CLEAR) |-> !in_ready)
    else $error("request accepted during store clear");

  // The sweep ends after its last row
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prgb_pkg::ST_CLEAR && st.sweep_last) |=> (state_r == prgb_pkg::ST_IDLE))
    else $error("store clear did not finish on its last row");

  // End of frame is reported with busy dropped
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_done |-> (!cmd.out_busy && state_r == prgb_pkg::ST_LOW))
    else $error("frame end flagged outside the final low time");

  // An accepted request always leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

@@ rtl/parallel_rgb_led_strip_driver.sv @@
`timescale 1ns / 1ps

// Eight-lane one-wire RGB LED strip driver. Each request (set colour, clear
// store, show frame, tick) returns exactly one result carrying the line levels
// driven during that request's clock, a busy flag and an end-of-frame flag.
// A request is taken in every cycle while the result register is free or being
// emptied, so ticks can arrive back to back and one tick is one waveform clock.
// The colour store is one memory per strip with MAX_LEDS rows; after reset and
// after every clear request it is zeroed by a sweep over all rows, one row per
// cycle, during which no request is taken. Configuration writes are honoured
// at all times but must only be issued while no frame is in progress.

module parallel_rgb_led_strip_driver #(
  parameter int STRIP_COUNT = 8,
  parameter int MAX_LEDS    = 32,
  parameter int COLOR_BITS  = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  prgb_req_if.sink                        in_req,
  prgb_res_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [prgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prgb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  prgb_pkg::cmd_t  cmd;
  prgb_pkg::stat_t st;

  // Sequencer
  prgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .req_type  (in_req.req_type),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Store, counters and line levels
  prgb_dpath #(
    .STRIP_COUNT (STRIP_COUNT),
    .MAX_LEDS    (MAX_LEDS),
    .COLOR_BITS  (COLOR_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .strip      (in_req.strip),
    .led        (in_req.led),
    .color      (in_req.color),
    .cmd        (cmd),
    .st         (st),
    .lines      (out_res.lines),
    .busy_res   (out_res.busy_res),
    .frame_done (out_res.frame_done)
  );

endmodule

@@ dv/parallel_rgb_led_strip_driver_test.sv @@
`timescale 1ns / 1ps

module parallel_rgb_led_strip_driver_test;

  localparam int NSTRIPS     = 8;
  localparam int NLEDS       = 32;
  localparam int NBITS       = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRESSURE_AT = 100;
  localparam int CALM_LO     = 300;
  localparam int CALM_HI     = 450;
  localparam int TOTAL_ITEMS = 700;
  localparam int NOISE_PCT   = 3;

  typedef struct packed {
    logic [prgb_pkg::LINES_W-1:0] lines;
    logic                         busy;
    logic                         done;
  } line_res_t;

  typedef struct packed {
    prgb_pkg::req_t               rq;
    logic [prgb_pkg::STRIP_W-1:0] st;
    logic [prgb_pkg::LED_W-1:0]   ld;
    logic [prgb_pkg::COLOR_W-1:0] col;
    logic                         typed;
    line_res_t                    want;
    logic                         run_out;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [prgb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [prgb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  prgb_req_if req_ch ();
  prgb_res_if res_ch ();

  parallel_rgb_led_strip_driver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: colour store, waveform position and register copies
  logic [prgb_pkg::COLOR_W-1:0] m_store [NSTRIPS][NLEDS];
  prgb_pkg::state_t             m_phase;
  int                           m_ticks;
  int                           m_bit;
  int                           m_led;
  logic [prgb_pkg::LINES_W-1:0] m_levels;
  int r_leds, r_high, r_data, r_low, r_reset;

  line_res_t pending_levels[$];
  int        mismatches;
  int        stall_cycles;
  int        item_count;
  bit        calm;
  bit        hold_req;
  bit        pressure_done;

  dir_row_t  dir_rows [0:14];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int at_least_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int frame_leds();
    int n;
    n = at_least_one(r_leds);
    return (n > NLEDS) ? NLEDS : n;
  endfunction

  function automatic void clear_store();
    foreach (m_store[s, l]) m_store[s][l] = '0;
  endfunction

  function automatic void model_reset();
    clear_store();
    m_phase  = prgb_pkg::ST_IDLE;
    m_ticks  = 0;
    m_bit    = 0;
    m_led    = 0;
    m_levels = '0;
    r_leds   = prgb_pkg::LEDS_RST;
    r_high   = prgb_pkg::HIGH_RST;
    r_data   = prgb_pkg::DATA_RST;
    r_low    = prgb_pkg::LOW_RST;
    r_reset  = prgb_pkg::RESET_RST;
  endfunction

  // Current colour bit of the current LED, one per strip
  function automatic logic [prgb_pkg::LINES_W-1:0] data_levels();
    logic [prgb_pkg::LINES_W-1:0] v;
    int pos;
    v = '0;
    if (m_led >= NLEDS || m_bit >= NBITS) return v;
    pos = NBITS - 1 - m_bit;
    if (pos > 23) return v;
    for (int s = 0; s < NSTRIPS; s++) v[s] = m_store[s][m_led][pos];
    return v;
  endfunction

  // Line levels, busy and end-of-frame flag for one request; advances the waveform
  function automatic line_res_t predict_lines(prgb_pkg::req_t rq,
                                              logic [prgb_pkg::STRIP_W-1:0] st,
                                              logic [prgb_pkg::LED_W-1:0] ld,
                                              logic [prgb_pkg::COLOR_W-1:0] col);
    line_res_t r;
    logic [prgb_pkg::LINES_W-1:0] now;
    now    = m_levels;
    r.done = 1'b0;
    if (rq == prgb_pkg::REQ_TICK) begin
      if (m_phase != prgb_pkg::ST_IDLE) begin
        if (m_ticks > 1) begin
          m_ticks--;
        end else begin
          case (m_phase)
            prgb_pkg::ST_LOW: begin
              if (m_led >= frame_leds()) begin
                m_phase  = prgb_pkg::ST_IDLE;
                m_ticks  = 0;
                m_levels = '0;
                r.done   = 1'b1;
              end else begin
                m_phase  = prgb_pkg::ST_HIGH;
                m_ticks  = at_least_one(r_high);
                m_levels = '1;
              end
            end
            prgb_pkg::ST_HIGH: begin
              m_phase  = prgb_pkg::ST_DATA;
              m_ticks  = at_least_one(r_data);
              m_levels = data_levels();
            end
            default: begin
              m_bit++;
              if (m_bit >= NBITS) begin
                m_bit = 0;
                m_led++;
              end
              m_phase  = prgb_pkg::ST_LOW;
              m_ticks  = at_least_one(r_low);
              m_levels = '0;
            end
          endcase
        end
      end
    end else if (m_phase == prgb_pkg::ST_IDLE) begin
      case (rq)
        prgb_pkg::REQ_SET: begin
          if (int'(st) < NSTRIPS && int'(ld) < NLEDS) m_store[st][ld] = col;
        end
        prgb_pkg::REQ_CLEAR: clear_store();
        default: begin
          m_phase  = prgb_pkg::ST_LOW;
          m_ticks  = at_least_one(r_reset);
          m_bit    = 0;
          m_led    = 0;
          m_levels = '0;
          now      = '0;
        end
      endcase
    end
    r.lines = now;
    r.busy  = (m_phase != prgb_pkg::ST_IDLE);
    return r;
  endfunction

  // Offer one request, wait for the transaction and record what must come back
  task automatic send_request(prgb_pkg::req_t rq, logic [prgb_pkg::STRIP_W-1:0] st,
                              logic [prgb_pkg::LED_W-1:0] ld,
                              logic [prgb_pkg::COLOR_W-1:0] col, bit typed,
                              line_res_t want);
    line_res_t pred;
    bit        counts;
    calm = (item_count >= CALM_LO && item_count < CALM_HI);
    while (!calm && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rq;
    req_ch.strip    <= st;
    req_ch.led      <= ld;
    req_ch.color    <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // ignored requests (non-tick while busy, tick while idle) do not count
    counts = ((rq == prgb_pkg::REQ_TICK) == (m_phase != prgb_pkg::ST_IDLE));
    pred   = predict_lines(rq, st, ld, col);
    pending_levels.push_back(typed ? want : pred);
    if (counts) item_count++;
  endtask

  task automatic send_random(prgb_pkg::req_t rq);
    send_request(rq, 3'($urandom_range(7)), 5'($urandom_range(31)),
                 24'($urandom), 1'b0, '0);
  endtask

  // Tick until the frame ends, with the odd ignored request mixed in
  task automatic run_out_frame();
    while (m_phase != prgb_pkg::ST_IDLE) begin
      if (!pressure_done && item_count >= PRESSURE_AT) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      if ($urandom_range(99) < NOISE_PCT) send_random(prgb_pkg::req_t'($urandom_range(2)));
      else send_random(prgb_pkg::REQ_TICK);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(prgb_pkg::cfg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= prgb_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      prgb_pkg::CFG_LEDS_IN_USE: r_leds  = val & 'h3f;
      prgb_pkg::CFG_HIGH_TICKS:  r_high  = val & 'hff;
      prgb_pkg::CFG_DATA_TICKS:  r_data  = val & 'hff;
      prgb_pkg::CFG_LOW_TICKS:   r_low   = val & 'hff;
      default:                   r_reset = val & 'hffff;
    endcase
  endtask

  // Timing registers change only with the block idle and nothing outstanding
  task automatic apply_timing(int leds, int hi, int da, int lo, int rs);
    wait_drained();
    cfg_write(prgb_pkg::CFG_LEDS_IN_USE, leds);
    cfg_write(prgb_pkg::CFG_HIGH_TICKS, hi);
    cfg_write(prgb_pkg::CFG_DATA_TICKS, da);
    cfg_write(prgb_pkg::CFG_LOW_TICKS, lo);
    cfg_write(prgb_pkg::CFG_RESET_TICKS, rs);
    cfg_we <= 1'b0;
  endtask

  // Load some colours, start a frame and tick it through to the end
  task automatic play_frame(int n_sets);
    int leds_now;
    logic [prgb_pkg::LED_W-1:0] ld;
    leds_now = frame_leds();
    if ($urandom_range(9) == 0) send_random(prgb_pkg::REQ_CLEAR);
    if ($urandom_range(9) == 0) send_random(prgb_pkg::REQ_TICK);
    repeat (n_sets) begin
      ld = ($urandom_range(9) < 8) ? 5'($urandom_range(leds_now - 1)) : 5'($urandom_range(31));
      send_request(prgb_pkg::REQ_SET, 3'($urandom_range(7)), ld, 24'($urandom), 1'b0, '0);
    end
    // last LED of the frame always carries data
    send_request(prgb_pkg::REQ_SET, 3'($urandom_range(7)), 5'(leds_now - 1), 24'($urandom),
                 1'b0, '0);
    send_random(prgb_pkg::REQ_SHOW);
    run_out_frame();
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    line_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: lines %02h busy %0b done %0b",
                   res_ch.lines, res_ch.busy_res, res_ch.frame_done);
      end else begin
        want = pending_levels.pop_front();
        if (res_ch.lines !== want.lines || res_ch.busy_res !== want.busy ||
            res_ch.frame_done !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: lines exp %02h got %02h, busy exp %0b got %0b, done exp %0b got %0b",
                     want.lines, res_ch.lines, want.busy, res_ch.busy_res,
                     want.done, res_ch.frame_done);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL parallel_rgb_led_strip_driver");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 8);
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    int n;
    mismatches    = 0;
    stall_cycles  = 0;
    item_count    = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    pressure_done = 1'b0;
    model_reset();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= prgb_pkg::REQ_TICK;
    req_ch.strip    <= '0;
    req_ch.led      <= '0;
    req_ch.color    <= '0;

    // directed rows under a short frame timing
    dir_rows = '{
      '{prgb_pkg::REQ_TICK,  3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd7, 5'd31, 24'hffffff, 1'b1, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd0, 5'd0,  24'h800001, 1'b0, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd3, 5'd0,  24'haaaaaa, 1'b0, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd7, 5'd0,  24'h555555, 1'b0, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd5, 5'd1,  24'hf0f00f, 1'b0, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd2, 5'd30, 24'h123456, 1'b0, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SHOW,  3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b0},
      // requests other than ticks are ignored during a frame
      '{prgb_pkg::REQ_SHOW,  3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_SET,   3'd1, 5'd1,  24'hffffff, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_CLEAR, 3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_TICK,  3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b1, 1'b0}, 1'b1},
      '{prgb_pkg::REQ_CLEAR, 3'd0, 5'd0,  24'h000000, 1'b1, '{8'h00, 1'b0, 1'b0}, 1'b0},
      '{prgb_pkg::REQ_TICK,  3'd5, 5'd9,  24'h00ff00, 1'b1, '{8'h00, 1'b0, 1'b0}, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    apply_timing(2, 1, 1, 1, 2);
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].rq, dir_rows[i].st, dir_rows[i].ld, dir_rows[i].col,
                   dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].run_out) run_out_frame();
    end

    // register extremes: zero counts act as one, writes wrap at the register widths
    apply_timing(0, 0, 0, 0, 0);
    play_frame(3);
    apply_timing(65, 256, 257, 258, 65536);
    play_frame(2);
    apply_timing(2, 0, 1, 0, 3);
    play_frame(4);

    // random timing and content
    while (item_count < TOTAL_ITEMS) begin
      apply_timing($urandom_range(2), $urandom_range(2), $urandom_range(2),
                   $urandom_range(2), $urandom_range(3));
      n = $urandom_range(1, 2);
      repeat (n) begin
        if ($urandom_range(9) == 0) send_random(prgb_pkg::req_t'($urandom_range(3)));
        play_frame($urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("PASS parallel_rgb_led_strip_driver");
    end else begin
      $display("FAIL parallel_rgb_led_strip_driver");
    end
    $finish;
  end

endmodule
